// ===== rtl/ztcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ztcw_pkg: shared types and constants of the archive record walker
// Walk phases, status codes, result word layout and name checker control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ztcw_pkg;

  localparam logic [31:0] ARC_MAGIC   = 32'h01ab_bbd6;
  localparam logic [31:0] FIRST_STAMP = 32'h0000_3bc4;
  localparam int unsigned FIXED_LEN   = 32'h12;
  localparam int unsigned OVERHEAD    = 32'h16;
  localparam int unsigned MIN_SPAN    = 28;
  localparam int unsigned HDR_LEN     = 10;
  localparam logic [7:0]  CH_LOW      = 8'h20;
  localparam logic [7:0]  CH_HIGH     = 8'h7e;
  localparam logic [7:0]  CH_BSLASH   = 8'h5c;
  localparam logic [7:0]  CH_SLASH    = 8'h2f;
  localparam logic [7:0]  CH_DOT      = 8'h2e;
  localparam logic [32:0] POS_MAX     = 33'h1_ffff_ffff;

  // configuration register indexes
  localparam logic        REG_SPAN    = 1'b0;
  localparam logic        REG_BASE    = 1'b1;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_COUNT     = 4'd3,
    ST_SIZE      = 4'd4,
    ST_NAMESIZE  = 4'd5,
    ST_TOTAL     = 4'd6,
    ST_STAMP     = 4'd7,
    ST_RANGE     = 4'd8,
    ST_CHECK     = 4'd9,
    ST_EMPTYNAME = 4'd10,
    ST_CHAR      = 4'd11,
    ST_PATH      = 4'd12
  } status_e;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_FIXED  = 6'b000100,
    PH_NAME   = 6'b001000,
    PH_CHECK  = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [16:0] record_index;
    logic [32:0] hdr_offset;
    logic [32:0] payload_offset;
    logic [30:0] packed_size;
    logic [30:0] raw_size;
    logic [12:0] name_chars;
    logic [31:0] arc_total;
    logic [16:0] record_count;
    logic        last;
  } res_t;

  // Name checker control from the walker
  typedef struct packed {
    logic       init;
    logic       byte_en;
    logic       last;
    logic [7:0] data;
  } nc_ctrl_t;

  // Name checker verdict
  typedef struct packed {
    logic        nul;
    logic        badchar;
    logic        pathbad;
    logic [12:0] chars;
  } nc_stat_t;

  // End-of-archive summary word
  function automatic res_t make_end(status_e st, logic [16:0] count, logic [31:0] size);
    res_t r;
    r              = '0;
    r.kind         = 1'b1;
    r.status       = st;
    r.arc_total    = size;
    r.record_count = count;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/ztcw_name_chk.sv =====
// ----------------------------------------------------------------------------
// ztcw_name_chk: record name rule checker
// Tracks NUL end, printable range, leading slash and dot-dot components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztcw_name_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ztcw_pkg::nc_ctrl_t ctrl_i,
  output ztcw_pkg::nc_stat_t stat_o
);

  logic        nul_q, nul_d;
  logic        bad_q, bad_d;
  logic        path_q, path_d;
  logic        dots_q, dots_d;
  logic [1:0]  len_q, len_d;
  logic [12:0] chars_q, chars_d;
  logic [7:0]  ch;

  // Per-byte update, then the closing of the last component
  always_comb begin
    nul_d   = nul_q;
    bad_d   = bad_q;
    path_d  = path_q;
    dots_d  = dots_q;
    len_d   = len_q;
    chars_d = chars_q;
    ch      = (ctrl_i.data == ztcw_pkg::CH_BSLASH) ? ztcw_pkg::CH_SLASH : ctrl_i.data;
    if (ctrl_i.init) begin
      nul_d   = 1'b0;
      bad_d   = 1'b0;
      path_d  = 1'b0;
      dots_d  = 1'b1;
      len_d   = 2'd0;
      chars_d = '0;
    end else if (ctrl_i.byte_en) begin
      if (!nul_q) begin
        if (ctrl_i.data == 8'd0) begin
          nul_d = 1'b1;
          if (len_q == 2'd2 && dots_q) path_d = 1'b1;
          len_d  = 2'd0;
          dots_d = 1'b1;
        end else begin
          chars_d = chars_q + 13'd1;
          if (ctrl_i.data < ztcw_pkg::CH_LOW || ctrl_i.data > ztcw_pkg::CH_HIGH) bad_d = 1'b1;
          if (ch == ztcw_pkg::CH_SLASH) begin
            if (chars_q == 13'd0) path_d = 1'b1;
            if (len_q == 2'd2 && dots_q) path_d = 1'b1;
            len_d  = 2'd0;
            dots_d = 1'b1;
          end else begin
            if (len_q != 2'd3) len_d = len_q + 2'd1;
            if (ch != ztcw_pkg::CH_DOT) dots_d = 1'b0;
          end
        end
      end
      // end of the name field closes the open component
      if (ctrl_i.last && !nul_d) begin
        if (len_d == 2'd2 && dots_d) path_d = 1'b1;
        len_d  = 2'd0;
        dots_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nul_q   <= 1'b0;
      bad_q   <= 1'b0;
      path_q  <= 1'b0;
      dots_q  <= 1'b0;
      len_q   <= 2'd0;
      chars_q <= '0;
    end else begin
      nul_q   <= nul_d;
      bad_q   <= bad_d;
      path_q  <= path_d;
      dots_q  <= dots_d;
      len_q   <= len_d;
      chars_q <= chars_d;
    end
  end

  assign stat_o.nul     = nul_q;
  assign stat_o.badchar = bad_q;
  assign stat_o.pathbad = path_q;
  assign stat_o.chars   = chars_q;

endmodule

// ===== rtl/ztc_archive_record_walker.sv =====
// ----------------------------------------------------------------------------
// ztc_archive_record_walker: chained record walker for archive byte streams
// Checks span and magic, validates each record, emits descriptors and a
// final summary word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | to block  | in_valid_i / in_stall_o | data_byte_i, start_req_i
//  out     | from block| out_valid_o / out_stall_i| kind_o .. last_o (11 fields)
//  cfg     | to block  | cfg_we_i               | cfg_addr_i, cfg_data_i
//
// One byte per cycle: each byte updates counters and flags in a single pass
// and its results go into a four-word output queue. A byte may yield up to
// two words; input stalls while fewer than two queue slots are free.
// Reset empties the queue and leaves the walk idle until a start byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztc_archive_record_walker #(
  parameter int unsigned MAX_RECORDS    = 100000,
  parameter int unsigned MAX_NAME_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  status_o,
  output logic [16:0] record_index_o,
  output logic [32:0] hdr_offset_o,
  output logic [32:0] payload_offset_o,
  output logic [30:0] packed_size_o,
  output logic [30:0] raw_size_o,
  output logic [12:0] name_chars_o,
  output logic [31:0] arc_total_o,
  output logic [16:0] record_count_o,
  output logic        last_o
);

  localparam logic [16:0] MaxRec  = 17'(MAX_RECORDS);
  localparam logic [15:0] MaxName = 16'(MAX_NAME_BYTES);

  // configuration
  logic [31:0] span_q, base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == ztcw_pkg::REG_BASE) base_q <= cfg_data_i;
      else                                  span_q <= cfg_data_i;
    end
  end

  // walk state
  ztcw_pkg::phase_e ph_q, ph_d;
  logic [32:0] bpos_q, bpos_d;
  logic [32:0] rs_q, rs_d;
  logic [31:0] fa_q, fa_d;
  logic [31:0] sf0_q, sf0_d, sf1_q, sf1_d, sf2_q, sf2_d;
  logic [12:0] held_q, held_d;
  logic [31:0] chk_q, chk_d;
  logic [12:0] cur_q, cur_d;
  logic [16:0] acc_q, acc_d;

  ztcw_pkg::nc_ctrl_t nc_ctrl;
  ztcw_pkg::nc_stat_t nc_stat;

  ztcw_name_chk u_name_chk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nc_ctrl),
    .stat_o (nc_stat)
  );

  // output queue
  ztcw_pkg::res_t qmem [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       in_acc, pop;
  ztcw_pkg::res_t r0, r1;
  logic [1:0] nres;

  assign in_stall_o  = cnt_q > 3'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o && !out_stall_i;

  // per-byte working values
  ztcw_pkg::phase_e ph;
  logic [32:0] pos, rs, span;
  logic [31:0] fa, fa_sh;
  logic [16:0] acc;
  logic [4:0]  rel;
  logic [15:0] ns;
  logic [33:0] rec_end, data_off, room, next;
  logic [34:0] next_tr;
  logic [31:0] packed_raw;
  logic [33:0] packed_cl;
  logic [13:0] cur_inc;
  logic [33:0] hoff, poff;
  logic [16:0] acc_inc;
  logic [31:0] asize;

  always_comb begin
    ph_d    = ph_q;
    bpos_d  = bpos_q;
    rs_d    = rs_q;
    fa_d    = fa_q;
    sf0_d   = sf0_q;
    sf1_d   = sf1_q;
    sf2_d   = sf2_q;
    held_d  = held_q;
    chk_d   = chk_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    nc_ctrl = '0;
    r0      = '0;
    r1      = '0;
    nres    = 2'd0;

    span    = {1'b0, span_q};
    pos     = start_req_i ? 33'd0 : bpos_q;
    rs      = start_req_i ? 33'd0 : rs_q;
    fa      = start_req_i ? 32'd0 : fa_q;
    acc     = start_req_i ? 17'd0 : acc_q;
    ph      = start_req_i ? ztcw_pkg::PH_HEADER : ph_q;
    fa_sh   = {data_byte_i, fa[31:8]};
    rel     = pos[4:0] - rs[4:0];
    ns      = fa_sh[31:16];
    rec_end = {1'b0, rs} + 34'(ns) + 34'(ztcw_pkg::OVERHEAD);
    cur_inc = {1'b0, cur_q} + 14'd1;
    data_off   = {1'b0, rs_q} + 34'(ztcw_pkg::OVERHEAD) + 34'(held_q);
    room       = {1'b0, span} - data_off;
    packed_raw = sf2_q - 32'(held_q) - 32'(ztcw_pkg::OVERHEAD);
    packed_cl  = (34'(packed_raw) > room) ? room : 34'(packed_raw);
    next       = {1'b0, rs_q} + 34'(sf2_q);
    next_tr    = {1'b0, next} + 35'd2;
    hoff       = 34'(base_q) + {1'b0, rs_q};
    poff       = 34'(base_q) + data_off;
    acc_inc    = acc_q + 17'd1;
    asize      = (next < {1'b0, span}) ? next[31:0] : span_q;

    if (in_acc) begin
      if (start_req_i) begin
        bpos_d = '0;
        rs_d   = '0;
        fa_d   = '0;
        acc_d  = '0;
        ph_d   = ztcw_pkg::PH_HEADER;
      end
      if (start_req_i && span_q < 32'(ztcw_pkg::MIN_SPAN)) begin
        ph_d = ztcw_pkg::PH_IDLE;
        r0   = ztcw_pkg::make_end(ztcw_pkg::ST_SHORT, 17'd0, 32'd0);
        nres = 2'd1;
      end else if (ph != ztcw_pkg::PH_IDLE) begin
        if (pos != ztcw_pkg::POS_MAX) bpos_d = pos + 33'd1;
        else                          bpos_d = pos;
        case (ph)
          ztcw_pkg::PH_HEADER: begin
            if (pos < 33'd4) fa_d = fa_sh;
            if (pos == 33'd3 && fa_sh != ztcw_pkg::ARC_MAGIC) begin
              ph_d = ztcw_pkg::PH_IDLE;
              r0   = ztcw_pkg::make_end(ztcw_pkg::ST_MAGIC, acc, 32'd0);
              nres = 2'd1;
            end
            if (pos == 33'(ztcw_pkg::HDR_LEN - 1)) begin
              rs_d = 33'(ztcw_pkg::HDR_LEN);
              ph_d = ztcw_pkg::PH_SKIP;
            end
          end
          ztcw_pkg::PH_SKIP, ztcw_pkg::PH_FIXED: begin
            if (ph == ztcw_pkg::PH_FIXED || pos == rs) begin
              ph_d = ztcw_pkg::PH_FIXED;
              fa_d = fa_sh;
              if (rel == 5'd0)  chk_d = 32'(data_byte_i);
              if (rel == 5'd12) chk_d = chk_q + 32'(data_byte_i);
              if (rel == 5'd3)  sf0_d = fa_sh;
              if (rel == 5'd7)  sf1_d = fa_sh;
              if (rel == 5'd11) sf2_d = fa_sh;
              if (rel == 5'(ztcw_pkg::FIXED_LEN - 1)) begin
                // fixed part checks; the first failing check sets the status
                r0   = '0;
                nres = 2'd1;
                if (sf0_q[31]) begin
                  r0 = ztcw_pkg::make_end(ztcw_pkg::ST_SIZE, acc, 32'd0);
                end else if (ns == 16'd0 || ns > MaxName) begin
                  r0 = ztcw_pkg::make_end(ztcw_pkg::ST_NAMESIZE, acc, 32'd0);
                end else if (sf2_q[31] ||
                             33'(sf2_q) < 33'(ns) + 33'(ztcw_pkg::OVERHEAD)) begin
                  r0 = ztcw_pkg::make_end(ztcw_pkg::ST_TOTAL, acc, 32'd0);
                end else if (acc == 17'd0 && sf1_q != ztcw_pkg::FIRST_STAMP) begin
                  r0 = ztcw_pkg::make_end(ztcw_pkg::ST_STAMP, acc, 32'd0);
                end else if (rs > span || rec_end > {1'b0, span}) begin
                  r0 = ztcw_pkg::make_end(ztcw_pkg::ST_RANGE, acc, 32'd0);
                end else begin
                  nres         = 2'd0;
                  held_d       = ns[12:0];
                  cur_d        = '0;
                  nc_ctrl.init = 1'b1;
                  ph_d         = ztcw_pkg::PH_NAME;
                end
                if (nres != 2'd0) ph_d = ztcw_pkg::PH_IDLE;
              end
            end
          end
          ztcw_pkg::PH_NAME: begin
            chk_d           = chk_q + 32'(data_byte_i);
            nc_ctrl.byte_en = 1'b1;
            nc_ctrl.data    = data_byte_i;
            nc_ctrl.last    = cur_inc >= {1'b0, held_q};
            cur_d           = cur_inc[12:0];
            if (nc_ctrl.last) begin
              cur_d = '0;
              ph_d  = ztcw_pkg::PH_CHECK;
            end
          end
          ztcw_pkg::PH_CHECK: begin
            fa_d  = fa_sh;
            cur_d = cur_inc[12:0];
            if (cur_inc >= 14'd4) begin
              nres = 2'd1;
              ph_d = ztcw_pkg::PH_IDLE;
              if (fa_sh != chk_q) begin
                r0 = ztcw_pkg::make_end(ztcw_pkg::ST_CHECK, acc_q, 32'd0);
              end else if (data_off > {1'b0, span}) begin
                r0 = ztcw_pkg::make_end(ztcw_pkg::ST_RANGE, acc_q, 32'd0);
              end else if (nc_stat.chars == 13'd0) begin
                r0 = ztcw_pkg::make_end(ztcw_pkg::ST_EMPTYNAME, acc_q, 32'd0);
              end else if (nc_stat.badchar) begin
                r0 = ztcw_pkg::make_end(ztcw_pkg::ST_CHAR, acc_q, 32'd0);
              end else if (nc_stat.pathbad) begin
                r0 = ztcw_pkg::make_end(ztcw_pkg::ST_PATH, acc_q, 32'd0);
              end else begin
                // record accepted: descriptor, then maybe the summary
                r0.kind           = 1'b0;
                r0.status         = ztcw_pkg::ST_OK;
                r0.record_index   = acc_q;
                r0.hdr_offset     = hoff[32:0];
                r0.payload_offset = poff[32:0];
                r0.packed_size    = packed_cl[30:0];
                r0.raw_size       = sf0_q[30:0];
                r0.name_chars     = nc_stat.chars;
                acc_d             = acc_inc;
                nres              = 2'd2;
                if (next_tr == {2'b0, span}) begin
                  r1 = ztcw_pkg::make_end(ztcw_pkg::ST_OK, acc_inc, asize);
                end else if (next + 34'(ztcw_pkg::FIXED_LEN) > {1'b0, span}) begin
                  r1 = ztcw_pkg::make_end(ztcw_pkg::ST_OK, acc_inc, asize);
                end else if (acc_inc >= MaxRec) begin
                  r1 = ztcw_pkg::make_end(ztcw_pkg::ST_COUNT, acc_inc, 32'd0);
                end else begin
                  nres = 2'd1;
                  rs_d = next[32:0];
                  ph_d = ztcw_pkg::PH_SKIP;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= ztcw_pkg::PH_IDLE;
      bpos_q <= '0;
      rs_q   <= '0;
      fa_q   <= '0;
      sf0_q  <= '0;
      sf1_q  <= '0;
      sf2_q  <= '0;
      held_q <= '0;
      chk_q  <= '0;
      cur_q  <= '0;
      acc_q  <= '0;
    end else begin
      ph_q   <= ph_d;
      bpos_q <= bpos_d;
      rs_q   <= rs_d;
      fa_q   <= fa_d;
      sf0_q  <= sf0_d;
      sf1_q  <= sf1_d;
      sf2_q  <= sf2_d;
      held_q <= held_d;
      chk_q  <= chk_d;
      cur_q  <= cur_d;
      acc_q  <= acc_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) qmem[wr_q] <= r0;
    if (nres == 2'd2) qmem[wr_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nres;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(nres) - 3'(pop);
    end
  end

  ztcw_pkg::res_t head;
  assign head             = qmem[rd_q];
  assign kind_o           = head.kind;
  assign status_o         = head.status;
  assign record_index_o   = head.record_index;
  assign hdr_offset_o     = head.hdr_offset;
  assign payload_offset_o = head.payload_offset;
  assign packed_size_o    = head.packed_size;
  assign raw_size_o       = head.raw_size;
  assign name_chars_o     = head.name_chars;
  assign arc_total_o      = head.arc_total;
  assign record_count_o   = head.record_count;
  assign last_o           = head.last;

endmodule

// ===== sim/ztc_archive_record_walker_tb.sv =====
// ----------------------------------------------------------------------------
// ztc_archive_record_walker_tb: self-checking bench for the record walker
// Streams generated archives (good chains, corrupted fields and names, short
// and clamped spans, restarts) through the byte port with random idling on
// both sides, predicts every descriptor and summary word and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztc_archive_record_walker_tb;

  localparam int unsigned REC_LIMIT  = 100000;
  localparam int unsigned NAME_LIMIT = 4096;
  localparam int unsigned DRAIN_CYC  = 16;
  localparam int unsigned ITEM_GOAL  = 1350;

  // Scoreboard: walks the archive alongside the block and queues its words
  class walk_ledger;
    logic [31:0] span, base;
    bit          done;
    ztcw_pkg::phase_e phase;
    longint unsigned pos, rec_start;
    logic [31:0] shreg, plain_sz, stamp, total_sz, csum;
    int unsigned name_sz, cursor, chars, accepted;
    bit          f_nul, f_bad, f_path, f_dots;
    int unsigned comp_len;
    ztcw_pkg::res_t expected_words[$];
    int unsigned errors;

    function new();
      span = '0; base = '0; done = 1'b1; phase = ztcw_pkg::PH_IDLE; pos = 0;
      rec_start = 0; shreg = '0; csum = '0; accepted = 0; errors = 0;
    endfunction

    function void push_end(ztcw_pkg::status_e st, longint unsigned size);
      expected_words.push_back(ztcw_pkg::make_end(st, accepted[16:0], size[31:0]));
      done = 1'b1;
      phase = ztcw_pkg::PH_IDLE;
    endfunction

    function void close_comp();
      if (comp_len == 2 && f_dots) f_path = 1'b1;
      comp_len = 0;
      f_dots = 1'b1;
    endfunction

    function void name_char(logic [7:0] b);
      csum += b;
      if (f_nul) return;
      if (b == 8'h00) begin
        f_nul = 1'b1;
        close_comp();
        return;
      end
      chars++;
      if (b < ztcw_pkg::CH_LOW || b > ztcw_pkg::CH_HIGH) f_bad = 1'b1;
      if (b == ztcw_pkg::CH_BSLASH) b = ztcw_pkg::CH_SLASH;
      if (b == ztcw_pkg::CH_SLASH) begin
        if (chars == 1) f_path = 1'b1;
        close_comp();
        return;
      end
      if (comp_len < 3) comp_len++;
      if (b != ztcw_pkg::CH_DOT) f_dots = 1'b0;
    endfunction

    // Fixed part complete: returns ST_OK or the failing status
    function ztcw_pkg::status_e fixed_status();
      int unsigned ns;
      ns = 32'(shreg[31:16]);
      if (plain_sz[31]) return ztcw_pkg::ST_SIZE;
      if (ns == 0 || ns > NAME_LIMIT) return ztcw_pkg::ST_NAMESIZE;
      if (total_sz[31] || total_sz < ns + ztcw_pkg::OVERHEAD) return ztcw_pkg::ST_TOTAL;
      if (accepted == 0 && stamp != ztcw_pkg::FIRST_STAMP) return ztcw_pkg::ST_STAMP;
      if (rec_start > span || longint'(ns) + ztcw_pkg::OVERHEAD > span - rec_start)
        return ztcw_pkg::ST_RANGE;
      name_sz = ns;
      return ztcw_pkg::ST_OK;
    endfunction

    function void accept_rec();
      longint unsigned data_off, pk, nxt;
      ztcw_pkg::res_t r;
      if (shreg != csum) begin push_end(ztcw_pkg::ST_CHECK, 0); return; end
      data_off = rec_start + ztcw_pkg::OVERHEAD + name_sz;
      pk = longint'(total_sz) - name_sz - ztcw_pkg::OVERHEAD;
      if (data_off > span) begin push_end(ztcw_pkg::ST_RANGE, 0); return; end
      if (pk > span - data_off) pk = span - data_off;
      if (chars == 0) begin push_end(ztcw_pkg::ST_EMPTYNAME, 0); return; end
      if (f_bad) begin push_end(ztcw_pkg::ST_CHAR, 0); return; end
      if (f_path) begin push_end(ztcw_pkg::ST_PATH, 0); return; end
      r = '0;
      r.record_index   = accepted[16:0];
      r.hdr_offset     = 33'(longint'(base) + rec_start);
      r.payload_offset = 33'(longint'(base) + data_off);
      r.packed_size    = pk[30:0];
      r.raw_size       = plain_sz[30:0];
      r.name_chars     = chars[12:0];
      expected_words.push_back(r);
      accepted++;
      nxt = rec_start + total_sz;
      if (nxt + 2 == span || nxt + ztcw_pkg::FIXED_LEN > span)
        push_end(ztcw_pkg::ST_OK, (nxt < span) ? nxt : span);
      else if (accepted >= REC_LIMIT)
        push_end(ztcw_pkg::ST_COUNT, 0);
      else begin
        rec_start = nxt;
        phase = ztcw_pkg::PH_SKIP;
      end
    endfunction

    // One accepted input word
    function void note_byte(logic [7:0] b, logic st);
      longint unsigned p, rel;
      ztcw_pkg::status_e fs;
      if (st) begin
        pos = 0; rec_start = 0; shreg = '0; accepted = 0;
        done = 1'b0; phase = ztcw_pkg::PH_HEADER;
        if (span < ztcw_pkg::MIN_SPAN) begin push_end(ztcw_pkg::ST_SHORT, 0); return; end
      end
      if (done) return;
      p = pos;
      if (pos < ztcw_pkg::POS_MAX) pos++;
      case (phase)
        ztcw_pkg::PH_HEADER: begin
          if (p < 4) shreg = {b, shreg[31:8]};
          if (p == 3 && shreg != ztcw_pkg::ARC_MAGIC) push_end(ztcw_pkg::ST_MAGIC, 0);
          else if (p == ztcw_pkg::HDR_LEN - 1) begin
            rec_start = ztcw_pkg::HDR_LEN;
            phase = ztcw_pkg::PH_SKIP;
          end
          return;
        end
        ztcw_pkg::PH_SKIP: begin
          if (p != rec_start) return;
          phase = ztcw_pkg::PH_FIXED;
        end
        default: ;
      endcase
      rel = p - rec_start;
      case (phase)
        ztcw_pkg::PH_FIXED: begin
          shreg = {b, shreg[31:8]};
          if (rel == 0) csum = 32'(b);
          else if (rel == 12) csum += b;
          if (rel == 3) plain_sz = shreg;
          else if (rel == 7) stamp = shreg;
          else if (rel == 11) total_sz = shreg;
          else if (rel == ztcw_pkg::FIXED_LEN - 1) begin
            fs = fixed_status();
            if (fs != ztcw_pkg::ST_OK) push_end(fs, 0);
            else begin
              cursor = 0; chars = 0; comp_len = 0;
              f_nul = 0; f_bad = 0; f_path = 0; f_dots = 1;
              phase = ztcw_pkg::PH_NAME;
            end
          end
        end
        ztcw_pkg::PH_NAME: begin
          name_char(b);
          cursor++;
          if (cursor >= name_sz) begin
            if (!f_nul) close_comp();
            cursor = 0;
            phase = ztcw_pkg::PH_CHECK;
          end
        end
        ztcw_pkg::PH_CHECK: begin
          shreg = {b, shreg[31:8]};
          cursor++;
          if (cursor >= 4) accept_rec();
        end
        default: ;
      endcase
    endfunction

    task report(string fld, longint unsigned got, longint unsigned exp);
      $display("mismatch %s: got 0x%0h expected 0x%0h", fld, got, exp);
      errors++;
    endtask

    task check_result(ztcw_pkg::res_t got);
      ztcw_pkg::res_t e;
      if (expected_words.size() == 0) begin
        report("unexpected word, status", got.status, 0);
        return;
      end
      e = expected_words.pop_front();
      if (got.kind != e.kind) report("kind", got.kind, e.kind);
      if (got.status != e.status) report("status", got.status, e.status);
      if (got.record_index != e.record_index)
        report("record_index", got.record_index, e.record_index);
      if (got.hdr_offset != e.hdr_offset)
        report("hdr_offset", got.hdr_offset, e.hdr_offset);
      if (got.payload_offset != e.payload_offset)
        report("payload_offset", got.payload_offset, e.payload_offset);
      if (got.packed_size != e.packed_size)
        report("packed_size", got.packed_size, e.packed_size);
      if (got.raw_size != e.raw_size) report("raw_size", got.raw_size, e.raw_size);
      if (got.name_chars != e.name_chars)
        report("name_chars", got.name_chars, e.name_chars);
      if (got.arc_total != e.arc_total)
        report("arc_total", got.arc_total, e.arc_total);
      if (got.record_count != e.record_count)
        report("record_count", got.record_count, e.record_count);
      if (got.last != e.last) report("last", got.last, e.last);
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_addr_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [7:0]  data_byte_i;
  logic        start_req_i;
  logic        out_valid_o, out_stall_i;
  ztcw_pkg::res_t got_w;

  walk_ledger  ledger;
  logic [7:0]  arc_q[$];
  int unsigned idle_pct, stall_pct, hold_left, sent;

  ztc_archive_record_walker DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .data_byte_i, .start_req_i,
    .out_valid_o, .out_stall_i,
    .kind_o(got_w.kind), .status_o(got_w.status), .record_index_o(got_w.record_index),
    .hdr_offset_o(got_w.hdr_offset), .payload_offset_o(got_w.payload_offset),
    .packed_size_o(got_w.packed_size), .raw_size_o(got_w.raw_size),
    .name_chars_o(got_w.name_chars), .arc_total_o(got_w.arc_total),
    .record_count_o(got_w.record_count), .last_o(got_w.last)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Output side: check each taken word against the ledger
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) ledger.check_result(got_w);

  // Receiver stall, with an occasional long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else
        out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(8 * 400000);
    $display("tb: failure");
    $finish;
  end

  task cfg_write(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ztcw_pkg::REG_SPAN) ledger.span = val; else ledger.base = val;
  endtask

  // Stop offering, wait for every expected word, then let the pipe settle
  task drain();
    in_valid_i <= 1'b0;
    while (ledger.expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  // Offer one word at a falling edge and hold it until taken
  task send_byte(logic [7:0] b, logic st);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; data_byte_i <= b; start_req_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_byte(b, st);
    sent++;
    @(negedge clk_i);
  endtask

  task send_bytes(int unsigned n);
    for (int unsigned i = 0; i < n && i < arc_q.size(); i++) send_byte(arc_q[i], i == 0);
  endtask

  function void push_le(logic [31:0] v, int unsigned nb);
    for (int unsigned i = 0; i < nb; i++) arc_q.push_back(v[8*i +: 8]);
  endfunction

  // Build an archive into arc_q, return the span to program
  function logic [31:0] build_archive(bit many);
    int unsigned nrec, ns, pay, total, last_pay, last_ns, k, sel;
    logic [31:0] plain, stmp, tot_f, tm, ns_f, ck;
    logic [7:0]  nm[$];
    string       pool;
    pool = "abcXYZ09_-.";
    arc_q = {};
    push_le(ztcw_pkg::ARC_MAGIC, 4);
    if ($urandom_range(24) == 0) arc_q[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < 6; i++) arc_q.push_back(8'($urandom));
    nrec = many ? 6 : $urandom_range(1, 4);
    for (int unsigned r = 0; r < nrec; r++) begin
      ns = $urandom_range(1, 6);
      pay = many ? 0 : $urandom_range(0, 5);
      total = ztcw_pkg::OVERHEAD + ns + pay;
      plain = $urandom & 32'h7fff_ffff;
      if ($urandom_range(29) == 0) plain[31] = 1'b1;
      stmp = (r == 0) ? ztcw_pkg::FIRST_STAMP : $urandom;
      if (r == 0 && $urandom_range(29) == 0) stmp ^= 32'(1 << $urandom_range(31));
      tot_f = total;
      sel = $urandom_range(59);
      if (sel == 0) tot_f = ns + ztcw_pkg::OVERHEAD - 1;
      else if (sel == 1) tot_f[31] = 1'b1;
      tm = $urandom;
      ns_f = ns;
      sel = $urandom_range(59);
      if (sel == 0) ns_f = 0;
      else if (sel == 1) ns_f = $urandom_range(NAME_LIMIT + 1, 16'hffff);
      nm = {};
      for (int unsigned i = 0; i < ns; i++) nm.push_back(pool[$urandom_range(pool.len() - 1)]);
      // Name damage: control or high char, separators, dot-dot, early or leading NUL
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(ns - 1);
        case ($urandom_range(6))
          0: nm[k] = $urandom_range(1) ? 8'($urandom_range(1, 31)) : 8'($urandom_range(127, 255));
          1: nm[k] = ztcw_pkg::CH_BSLASH;
          2: nm[0] = $urandom_range(1) ? ztcw_pkg::CH_SLASH : ztcw_pkg::CH_BSLASH;
          3: begin
            nm[0] = ztcw_pkg::CH_DOT;
            if (ns > 1) nm[1] = ztcw_pkg::CH_DOT;
            if (ns > 2) nm[2] = $urandom_range(1) ? ztcw_pkg::CH_SLASH : ztcw_pkg::CH_BSLASH;
          end
          4: nm[k] = 8'h00;
          5: nm[0] = 8'h00;
          default: begin
            nm[k] = ztcw_pkg::CH_SLASH;
            if (k + 2 < ns) begin nm[k+1] = ztcw_pkg::CH_DOT; nm[k+2] = ztcw_pkg::CH_DOT; end
          end
        endcase
      end
      push_le(plain, 4); push_le(stmp, 4); push_le(tot_f, 4); push_le(tm, 4);
      push_le(ns_f, 2);
      ck = plain[7:0] + tm[7:0];
      foreach (nm[i]) begin
        arc_q.push_back(nm[i]);
        ck += nm[i];
      end
      if ($urandom_range(24) == 0) ck ^= 32'(1 << $urandom_range(31));
      push_le(ck, 4);
      for (int unsigned i = 0; i < pay; i++) arc_q.push_back(8'($urandom));
      last_pay = pay;
      last_ns = ns;
    end
    case ($urandom_range(9))
      0: return arc_q.size();
      1: return arc_q.size() - $urandom_range(0, last_pay);
      2: return $urandom_range(0, ztcw_pkg::MIN_SPAN - 1);
      3: return arc_q.size() - last_pay - $urandom_range(1, last_ns + 4);
      4: return arc_q.size() + $urandom_range(1, ztcw_pkg::FIXED_LEN - 1);
      default: return arc_q.size() + 2;
    endcase
  endfunction

  // Program span and base for the next archive, block idle
  task setup(logic [31:0] span);
    logic [31:0] b;
    drain();
    case ($urandom_range(5))
      0: b = '0;
      1: b = '1;
      default: b = $urandom;
    endcase
    cfg_write(ztcw_pkg::REG_SPAN, span);
    cfg_write(ztcw_pkg::REG_BASE, b);
  endtask

  initial begin
    logic [31:0] sp;
    ledger = new();
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_addr_i = ztcw_pkg::REG_SPAN; cfg_data_i = '0;
    in_valid_i = 1'b0; data_byte_i = '0; start_req_i = 1'b0;
    idle_pct = 0; stall_pct = 0; hold_left = 0; sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: stray words before any start, short spans, widest span
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    setup(32'd0);
    send_byte(8'h5a, 1'b1);
    setup(ztcw_pkg::MIN_SPAN - 1);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h11, 1'b0);
    setup(32'hffff_ffff);
    send_byte(8'hd6, 1'b1);
    send_byte(8'hbb, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'h02, 1'b0);
    // Restart in mid-walk, then the same archive whole
    sp = build_archive(1'b0);
    setup(arc_q.size() + 2);
    send_bytes(15);
    send_bytes(arc_q.size());

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 27 : 0;
      stall_pct = (ph == 2) ? 46 : (ph == 3) ? 27 : 0;
      while (sent < ITEM_GOAL * (ph + 1) / 4) begin
        sp = build_archive(ph == 0 && sent < 300);
        setup(sp);
        if (ph == 0 && sent < 300) hold_left = 300;
        send_bytes(arc_q.size());
      end
    end
    drain();
    if (ledger.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ztcw_pkg.sv
rtl/ztcw_name_chk.sv
rtl/ztc_archive_record_walker.sv
sim/ztc_archive_record_walker_tb.sv
